// ===== design/rb2ds_pkg.sv =====
// Shared register map and reset constants for the 2x2 box downsampler.
package rb2ds_pkg;

    localparam int CFG_ADDR_BITS  = 4;
    localparam int ROW_WIDTH_BITS = 14;
    localparam int CODE_BITS      = 16;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH   = 2'd0,
        REG_NODATA_CODE = 2'd1,
        REG_NODATA_SUB  = 2'd2
    } reg_index_t;

    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET   = 14'd8192;
    localparam logic [CODE_BITS-1:0]      NODATA_CODE_RESET = 16'hD8F1;
    localparam logic [CODE_BITS-1:0]      NODATA_SUB_RESET  = 16'hFFFF;

endpackage

// ===== design/rb2ds_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module rb2ds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/raster_box2x2_downsampler_top.sv =====
// Top level of the raster 2x2 box-filter downsampler with its line store.
//
//  Channel  Handshake                 Payload
//  pixel    pixel_valid/pixel_stall   pixel_value, pixel_is_number
//  block    block_valid/block_stall   block_mean, row_last
//  config   psel/penable/pready       paddr, pwrite, pwdata, prdata
//
// One pixel transfer per cycle; block_valid passes stages 1 and 2 and the output register.
// The rate is set by the line store: two banks (even and odd columns), one access each.
// Reset clears the counters and pipeline; the line store has no clearing pass.
// Pixel transfers stop only while the result pipeline is full and block_stall holds it.
module raster_box2x2_downsampler_top
    import rb2ds_pkg::*;
#(
    parameter int LINE_MAX   = 8192,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic signed [PIXEL_BITS-1:0] pixel_value,
    input  logic                         pixel_is_number,
    output logic                         block_valid,
    input  logic                         block_stall,
    output logic signed [PIXEL_BITS-1:0] block_mean,
    output logic                         row_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int WW         = $clog2(LINE_MAX + 1);
    localparam int BANK_DEPTH = (LINE_MAX + 1) / 2;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CW         = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;
    localparam int SW         = CW + 2;
    localparam int EW         = PIXEL_BITS + 1;

    logic [ROW_WIDTH_BITS-1:0] row_width_reg;
    logic [CODE_BITS-1:0]      nodata_code_reg;
    logic [CODE_BITS-1:0]      nodata_sub_reg;
    logic                      cfg_write;
    reg_index_t                cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= ROW_WIDTH_RESET;
            nodata_code_reg <= NODATA_CODE_RESET;
            nodata_sub_reg  <= NODATA_SUB_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:   row_width_reg   <= pwdata[ROW_WIDTH_BITS-1:0];
                REG_NODATA_CODE: nodata_code_reg <= pwdata[CODE_BITS-1:0];
                REG_NODATA_SUB:  nodata_sub_reg  <= pwdata[CODE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ROW_WIDTH:   prdata = 32'(row_width_reg);
            REG_NODATA_CODE: prdata = 32'(nodata_code_reg);
            REG_NODATA_SUB:  prdata = 32'(nodata_sub_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // Effective row width and column position.
    logic [WW-1:0] width_eff;
    logic [WW-1:0] count_reg, count_next;
    logic          odd_reg, odd_next;
    logic          wrap_now;
    logic [WW-1:0] col;
    logic          odd_eff;
    logic [WW:0]   col_inc;
    logic          end_row;
    logic [WW-1:0] last_col;
    logic [WW-1:0] col_half;
    logic          accept;

    always_comb
    begin
        if (row_width_reg < 14'd2)
        begin
            width_eff = WW'(2);
        end
        else if (32'(row_width_reg) > LINE_MAX)
        begin
            width_eff = WW'(LINE_MAX);
        end
        else
        begin
            width_eff = WW'(row_width_reg);
        end
    end

    assign wrap_now = (count_reg >= width_eff);
    assign col      = wrap_now ? '0 : count_reg;
    assign odd_eff  = odd_reg ^ wrap_now;
    assign col_inc  = {1'b0, col} + (WW + 1)'(1);
    assign end_row  = (col_inc >= {1'b0, width_eff});
    assign last_col = {width_eff[WW-1:1], 1'b0} - WW'(1);
    assign col_half = col >> 1;

    always_comb
    begin
        count_next = count_reg;
        odd_next   = odd_reg;
        if (accept)
        begin
            count_next = end_row ? '0 : col_inc[WW-1:0];
            odd_next   = odd_eff ^ end_row;
        end
    end

    // Line store: one bank for even columns, one for odd columns.
    logic          ram_we_even, ram_we_odd, ram_re;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] rdata_even, rdata_odd;

    assign ram_addr    = col_half[AW-1:0];
    assign ram_wdata   = {pixel_is_number, pixel_value};
    assign ram_we_even = accept && !odd_eff && !col[0];
    assign ram_we_odd  = accept && !odd_eff && col[0];
    assign ram_re      = accept && odd_eff;

    rb2ds_ram #(
        .WIDTH (EW),
        .DEPTH (BANK_DEPTH)
    ) u_ram_even (
        .clk   (clk),
        .we    (ram_we_even),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata_even)
    );

    rb2ds_ram #(
        .WIDTH (EW),
        .DEPTH (BANK_DEPTH)
    ) u_ram_odd (
        .clk   (clk),
        .we    (ram_we_odd),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata_odd)
    );

    // Held left pixel of the lower row.
    logic [EW-1:0] held_reg, held_next;

    always_comb
    begin
        held_next = held_reg;
        if (accept && odd_eff && !col[0])
        begin
            held_next = ram_wdata;
        end
    end

    // Pipeline: stage 1 waits for the line store, stage 2 substitutes, the output register sums.
    logic          s1_valid_reg, s1_valid_next;
    logic [EW-1:0] s1_left_reg, s1_left_next;
    logic [EW-1:0] s1_right_reg, s1_right_next;
    logic          s1_last_reg, s1_last_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic signed [CW-1:0] s2_val_reg [4];
    logic signed [CW-1:0] s2_val_next [4];
    logic                 s2_last_reg, s2_last_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [PIXEL_BITS-1:0] block_mean_reg, block_mean_next;
    logic                         row_last_reg, row_last_next;
    logic out_ready, s2_ready, s1_ready;
    logic block_ok;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_adj;
    logic signed [SW-1:0] mean;

    function automatic logic signed [CW-1:0] subst(input logic [EW-1:0] e,
                                                   input logic [CODE_BITS-1:0] code,
                                                   input logic [CODE_BITS-1:0] sub);
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        v = CW'($signed(e[PIXEL_BITS-1:0]));
        c = CW'($signed(code));
        s = CW'($signed(sub));
        return (v == c) ? s : v;
    endfunction

    assign out_ready   = !out_valid_reg || !block_stall;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_stall = !s1_ready;
    assign accept      = pixel_valid && !pixel_stall;

    assign block_ok = rdata_even[EW-1] && rdata_odd[EW-1] &&
                      s1_left_reg[EW-1] && s1_right_reg[EW-1];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_left_next  = s1_left_reg;
        s1_right_next = s1_right_reg;
        s1_last_next  = s1_last_reg;
        if (s1_ready)
        begin
            s1_valid_next = accept && odd_eff && col[0];
            s1_left_next  = held_reg;
            s1_right_next = ram_wdata;
            s1_last_next  = (col == last_col);
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_val_next   = s2_val_reg;
        s2_last_next  = s2_last_reg;
        if (s2_ready)
        begin
            s2_valid_next  = s1_valid_reg && block_ok;
            s2_val_next[0] = subst(rdata_even, nodata_code_reg, nodata_sub_reg);
            s2_val_next[1] = subst(rdata_odd, nodata_code_reg, nodata_sub_reg);
            s2_val_next[2] = subst(s1_left_reg, nodata_code_reg, nodata_sub_reg);
            s2_val_next[3] = subst(s1_right_reg, nodata_code_reg, nodata_sub_reg);
            s2_last_next   = s1_last_reg;
        end
    end

    // Division by four rounds toward zero, so negative sums are biased by three.
    assign sum     = SW'(s2_val_reg[0]) + SW'(s2_val_reg[1]) +
                     SW'(s2_val_reg[2]) + SW'(s2_val_reg[3]);
    assign sum_adj = sum + ((sum < 0) ? SW'(3) : SW'(0));
    assign mean    = sum_adj >>> 2;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        block_mean_next = block_mean_reg;
        row_last_next   = row_last_reg;
        if (out_ready)
        begin
            out_valid_next  = s2_valid_reg;
            block_mean_next = mean[PIXEL_BITS-1:0];
            row_last_next   = s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            odd_reg       <= 1'b0;
            held_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            odd_reg       <= odd_next;
            held_reg      <= held_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_left_reg    <= s1_left_next;
        s1_right_reg   <= s1_right_next;
        s1_last_reg    <= s1_last_next;
        s2_val_reg     <= s2_val_next;
        s2_last_reg    <= s2_last_next;
        block_mean_reg <= block_mean_next;
        row_last_reg   <= row_last_next;
    end

    assign block_valid = out_valid_reg;
    assign block_mean  = block_mean_reg;
    assign row_last    = row_last_reg;

`ifndef ASSERT_OFF
    a_store_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && (ram_we_even || ram_we_odd)))
        else $error("line store read and written in the same cycle");

    a_block_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && odd_eff && col[0]) |=> s1_valid_reg)
        else $error("block-completing pixel did not reach stage 1");

    a_empty_stage_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !pixel_stall)
        else $error("pixel channel stalled with an empty pipeline");

    a_stage1_holds_store: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> ($stable(rdata_even) && $stable(rdata_odd)))
        else $error("line store data changed under a stalled stage 1");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the raster 2x2 box downsampler: a directed table, then random phases.
`timescale 1ns / 1ps

module tb
    import rb2ds_pkg::*;
();

    localparam int LINE_MAX    = 8192;
    localparam int PIXEL_BITS  = 16;
    localparam int RAND_ITEMS  = 1500;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [1:0] {
        EXP_NONE,
        EXP_BLOCK,
        EXP_PRED
    } exp_kind_t;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_MAX,
        PH_PRESSURE,
        PH_WIDE_PART,
        PH_SHRINK
    } phase_kind_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               num;
        exp_kind_t          kind;
        logic signed [15:0] mean;
        logic               last;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         pixel_valid;
    logic                         pixel_stall;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         pixel_is_number;
    logic                         block_valid;
    logic                         block_stall;
    logic signed [PIXEL_BITS-1:0] block_mean;
    logic                         row_last;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [CFG_ADDR_BITS-1:0]     paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    raster_box2x2_downsampler_top #(
        .LINE_MAX   (LINE_MAX),
        .PIXEL_BITS (PIXEL_BITS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_valid     (pixel_valid),
        .pixel_stall     (pixel_stall),
        .pixel_value     (pixel_value),
        .pixel_is_number (pixel_is_number),
        .block_valid     (block_valid),
        .block_stall     (block_stall),
        .block_mean      (block_mean),
        .row_last        (row_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    logic signed [15:0] line_val [0:LINE_MAX-1];
    logic               line_num [0:LINE_MAX-1];
    int                 col_pos;
    logic               odd_row;
    logic signed [15:0] held_val;
    logic               held_num;
    logic [13:0]        cfg_width;
    logic signed [15:0] cfg_code;
    logic signed [15:0] cfg_sub;

    logic [16:0] pending_blocks [$];
    stim_row_t   stim_tbl [$];
    logic [16:0] oldest_block;

    int errors       = 0;
    int pixels_sent  = 0;
    int blocks_seen  = 0;
    int reg_writes   = 0;
    int tx_mode      = 1;
    int rx_mode      = 1;
    int hold_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
        begin
            $display("tb: mismatch in %s: got %0d, expected %0d (after %0d pixel transfers)",
                     what, got, want, pixels_sent);
        end
    endtask

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default: return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic int eff_width();
        if (cfg_width < 2)
            return 2;
        else if (cfg_width > LINE_MAX)
            return LINE_MAX;
        else
            return int'(cfg_width);
    endfunction

    function automatic int pixels_to_align();
        int   e;
        int   c;
        logic odd;
        e   = eff_width();
        c   = col_pos;
        odd = odd_row;
        if (c >= e)
        begin
            c   = 0;
            odd = ~odd;
        end
        return odd ? (e - c) : ((e - c) + e);
    endfunction

    function automatic int subst(input logic signed [15:0] x);
        return (x == cfg_code) ? int'(cfg_sub) : int'(x);
    endfunction

    task automatic predict_block(input logic signed [15:0] v, input logic n,
                                 output bit hit, output logic [16:0] blk);
        int                 e;
        int                 c;
        int                 sum;
        logic signed [15:0] mean;
        e   = eff_width();
        hit = 1'b0;
        blk = '0;
        if (col_pos >= e)
        begin
            col_pos = 0;
            odd_row = ~odd_row;
        end
        c = col_pos;
        if (!odd_row)
        begin
            line_val[c] = v;
            line_num[c] = n;
        end
        else if (c % 2 == 0)
        begin
            held_val = v;
            held_num = n;
        end
        else if (line_num[c-1] && line_num[c] && held_num && n)
        begin
            sum  = subst(line_val[c-1]) + subst(line_val[c]) + subst(held_val) + subst(v);
            mean = 16'(sum / 4);
            hit  = 1'b1;
            blk  = {mean, (c == ((e & ~1) - 1))};
        end
        if (c + 1 >= e)
        begin
            col_pos = 0;
            odd_row = ~odd_row;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
        logic [31:0] rd;
        int          bits;
        bits = (idx == REG_ROW_WIDTH) ? ROW_WIDTH_BITS : CODE_BITS;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ROW_WIDTH:   cfg_width = data[13:0];
            REG_NODATA_CODE: cfg_code  = data[15:0];
            default:         cfg_sub   = data[15:0];
        endcase
        reg_writes++;
        if (((rd ^ data) & ((32'd1 << bits) - 32'd1)) != 32'd0)
            report_mismatch("register read-back", int'(rd), int'(data));
    endtask

    task automatic send_pixel(input logic signed [15:0] v, input logic n);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid     <= 1'b1;
        pixel_value     <= v;
        pixel_is_number <= n;
        do @(posedge clk); while (!(pixel_valid && !pixel_stall));
        pixels_sent++;
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_row(input logic signed [15:0] v, input logic n, input exp_kind_t k,
                           input logic signed [15:0] m, input logic l);
        stim_row_t r;
        r.value = v;
        r.num   = n;
        r.kind  = k;
        r.mean  = m;
        r.last  = l;
        stim_tbl.insert(stim_tbl.size(), r);
    endtask

    function automatic logic signed [15:0] gen_pixel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return cfg_code;
            3, 4:    return 16'(int'($urandom_range(0, 16)) - 8);
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_code(input logic [15:0] usual);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'h0000_8000;
            1:       return 32'h0000_7FFF;
            2:       return {16'h0000, usual};
            default: return {16'h0000, r[15:0]};
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(13, 40);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && block_valid === 1'b1 && !block_stall)
        begin
            blocks_seen++;
            if (pending_blocks.size() == 0)
            begin
                report_mismatch("block transfer with none expected", int'(block_mean), 0);
            end
            else
            begin
                oldest_block = pending_blocks.pop_front();
                if (block_mean !== oldest_block[16:1])
                    report_mismatch("block_mean", int'(block_mean),
                                    int'($signed(oldest_block[16:1])));
                if (row_last !== oldest_block[0])
                    report_mismatch("row_last", int'(row_last), int'(oldest_block[0]));
            end
        end
    end

    initial
    begin : rx_side
        int n;
        block_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                n = draw_wait(rx_mode);
            end
            if (n > 0)
            begin
                block_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            block_stall <= 1'b0;
            do @(posedge clk); while (!(block_valid === 1'b1 && !block_stall));
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (block_valid === 1'b1 && !block_stall) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : main_flow
        bit          hit;
        logic [16:0] blk;
        int          rand_items;
        int          phase_no;
        int          npix;
        int          e;
        int          k;
        phase_kind_t kind;
        bit          max_done;
        bit          press_done;
        bit          wide_done;
        bit          shrink_due;

        rand_items = 0;
        phase_no   = 0;
        max_done   = 0;
        press_done = 0;
        wide_done  = 0;
        shrink_due = 0;

        rst_n           <= 1'b0;
        pixel_valid     <= 1'b0;
        pixel_value     <= '0;
        pixel_is_number <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;

        cfg_width = ROW_WIDTH_RESET;
        cfg_code  = NODATA_CODE_RESET;
        cfg_sub   = NODATA_SUB_RESET;
        col_pos   = 0;
        odd_row   = 1'b0;
        held_val  = '0;
        held_num  = 1'b0;

        add_row(16'sh7FFF,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh7FFF,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh7FFF,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh7FFF,  1'b1, EXP_BLOCK, 16'sh7FFF, 1'b1);
        add_row(16'sh8000,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh8000,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh8000,  1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sh8000,  1'b1, EXP_BLOCK, 16'sh8000, 1'b1);
        add_row(-16'sd2,    1'b1, EXP_NONE,  '0, 1'b0);
        add_row(-16'sd1,    1'b1, EXP_NONE,  '0, 1'b0);
        add_row(-16'sd1,    1'b1, EXP_NONE,  '0, 1'b0);
        add_row(-16'sd1,    1'b1, EXP_PRED,  '0, 1'b0);
        add_row(-16'sd9999, 1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd4,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd4,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd4,     1'b1, EXP_PRED,  '0, 1'b0);
        add_row(16'sd5,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd5,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd5,     1'b0, EXP_NONE,  '0, 1'b0);
        add_row(16'sd5,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(-16'sd9999, 1'b0, EXP_NONE,  '0, 1'b0);
        add_row(16'sd7,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd7,     1'b1, EXP_NONE,  '0, 1'b0);
        add_row(16'sd7,     1'b1, EXP_NONE,  '0, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(REG_ROW_WIDTH, 32'd2);
        tx_mode = 1;
        rx_mode = 1;
        foreach (stim_tbl[i])
        begin
            send_pixel(stim_tbl[i].value, stim_tbl[i].num);
            predict_block(stim_tbl[i].value, stim_tbl[i].num, hit, blk);
            case (stim_tbl[i].kind)
                EXP_BLOCK:
                begin
                    pending_blocks.insert(pending_blocks.size(),
                                          {stim_tbl[i].mean, stim_tbl[i].last});
                end
                EXP_PRED:
                begin
                    if (hit)
                        pending_blocks.insert(pending_blocks.size(), blk);
                end
                default:   ;
            endcase
        end
        pixel_valid <= 1'b0;
        drain();

        while (rand_items < RAND_ITEMS)
        begin
            phase_no++;
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);

            if (!odd_row && !max_done && phase_no >= 4)
                kind = PH_MAX;
            else if (!odd_row && !press_done && phase_no >= 7)
                kind = PH_PRESSURE;
            else if (!odd_row && !wide_done && phase_no >= 10)
                kind = PH_WIDE_PART;
            else if (shrink_due)
                kind = PH_SHRINK;
            else
                kind = PH_NORMAL;

            case (kind)
                PH_MAX:       cfg_write(REG_ROW_WIDTH, 32'd16383);
                PH_PRESSURE:  cfg_write(REG_ROW_WIDTH, 32'd2);
                PH_WIDE_PART: cfg_write(REG_ROW_WIDTH, 32'd8192);
                PH_SHRINK:    cfg_write(REG_ROW_WIDTH, $urandom_range(2, 12));
                default:
                begin
                    if (!odd_row && $urandom_range(0, 3) != 0)
                        cfg_write(REG_ROW_WIDTH, pick_width());
                end
            endcase
            if (phase_no == 1 || $urandom_range(0, 1) == 1)
                cfg_write(REG_NODATA_CODE, pick_code(16'hD8F1));
            if (phase_no == 1 || $urandom_range(0, 1) == 1)
                cfg_write(REG_NODATA_SUB, pick_code(16'hFFFF));

            e = eff_width();
            case (kind)
                PH_MAX:
                begin
                    npix       = $urandom_range(20, 60);
                    tx_mode    = 1;
                    max_done   = 1;
                    shrink_due = 1;
                end
                PH_PRESSURE:
                begin
                    npix        = pixels_to_align() + 240;
                    tx_mode     = 0;
                    rx_mode     = 0;
                    hold_cycles = HOLD_CYCLES;
                    press_done  = 1;
                end
                PH_WIDE_PART:
                begin
                    npix       = $urandom_range(20, 60);
                    wide_done  = 1;
                    shrink_due = 1;
                end
                PH_SHRINK:
                begin
                    npix       = pixels_to_align() + 2 * e * $urandom_range(0, 2);
                    shrink_due = 0;
                end
                default:
                begin
                    k    = $urandom_range(0, 3);
                    npix = pixels_to_align() + 2 * e * k;
                    if ($urandom_range(0, 2) == 0)
                        npix += $urandom_range(1, e - 1);
                    if ($urandom_range(0, 5) == 0)
                        npix = $urandom_range(1, 3 * e);
                end
            endcase

            for (int i = 0; i < npix; i++)
            begin
                logic signed [15:0] v;
                logic               n;
                v = gen_pixel();
                n = ($urandom_range(0, 15) != 0);
                send_pixel(v, n);
                predict_block(v, n, hit, blk);
                if (hit)
                    pending_blocks.insert(pending_blocks.size(), blk);
                rand_items++;
            end
            pixel_valid <= 1'b0;
            drain();
        end

        $display("tb: %0d pixel transfers, %0d block results checked, %0d register writes",
                 pixels_sent, blocks_seen, reg_writes);
        $display("tb: clamped and odd widths, narrowing, no-data swaps and hold-off covered");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
